// ===== design/atscm_pkg.sv =====
package atscm_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int LANES        = 4;
  localparam int SAMPLE_W     = 16;
  localparam int LABEL_W      = 8;
  localparam int LABELS_W     = LANES * LABEL_W;
  localparam int CNT_W        = 3;
  localparam int IDX_W        = $clog2(LANES);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  // four 16-bit samples summed need two more bits
  localparam int SUM_W        = SAMPLE_W + 2;

  localparam logic [CNT_W-1:0] CNT_LIM =
    CNT_W'((MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES);

  // floor(n/3) == (n * RECIP3) >> RECIP3_SH for every n below 2^19
  localparam logic [SUM_W-1:0] RECIP3    = SUM_W'(174763);
  localparam int               RECIP3_SH = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_LABELS   = 3'd0,
    CFG_SRC1_LABELS  = 3'd1,
    CFG_SRC2_LABELS  = 3'd2,
    CFG_OUT_COUNT    = 3'd3,
    CFG_SRC1_COUNT   = 3'd4,
    CFG_SRC2_COUNT   = 3'd5,
    CFG_CENTER_LABEL = 3'd6
  } cfg_idx_t;

  typedef logic [SAMPLE_W-1:0]            sample_t;
  typedef logic [LANES-1:0][SAMPLE_W-1:0] frame_t;

  // label map of one source with its effective channel count
  typedef struct packed {
    logic [LABELS_W-1:0] labels;
    logic [CNT_W-1:0]    cnt;
  } src_map_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    if (c == '0) begin
      return CNT_W'(1);
    end else if (c > CNT_LIM) begin
      return CNT_LIM;
    end else begin
      return c;
    end
  endfunction

endpackage

// ===== design/audio_two_source_channel_muxer_top.sv =====
// Two-source audio channel muxer.
// Input channel: one beat carries a frame of four signed 16-bit samples from
// each source (in_a_ch*, in_b_ch*). Output channel: one beat carries four
// output samples (out_o_ch*). Each output lane looks up its label in both
// source label maps in parallel; source 2 wins over source 1, unmatched and
// unused lanes give zero. With one output channel, lane 0 carries the
// average of source 2's channels, truncated toward zero.
// Throughput: one beat per cycle while out_stall is low, set by the
// two-register pipeline (lane match stage, then merge/output register).
// An accepted beat is registered in the match stage, then in the output
// register, which drives the output.
// Stall: out_stall holds the output register; the match stage still fills,
// and in_stall rises only when both stages hold data.
// Config: cfg_ready is always high; write only while the block is idle.
// Reset (rst_n low, synchronous): pipeline empties, label maps clear to 0,
// counts go to 1 and the center label to 0.
module audio_two_source_channel_muxer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [atscm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atscm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_a_ch0,
  input  logic signed [15:0]                  in_a_ch1,
  input  logic signed [15:0]                  in_a_ch2,
  input  logic signed [15:0]                  in_a_ch3,
  input  logic signed [15:0]                  in_b_ch0,
  input  logic signed [15:0]                  in_b_ch1,
  input  logic signed [15:0]                  in_b_ch2,
  input  logic signed [15:0]                  in_b_ch3,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_o_ch0,
  output logic signed [15:0]                  out_o_ch1,
  output logic signed [15:0]                  out_o_ch2,
  output logic signed [15:0]                  out_o_ch3
);

  logic [atscm_pkg::LABELS_W-1:0] out_labels_r;
  logic [atscm_pkg::LABELS_W-1:0] src1_labels_r;
  logic [atscm_pkg::LABELS_W-1:0] src2_labels_r;
  logic [atscm_pkg::CNT_W-1:0]    out_count_r;
  logic [atscm_pkg::CNT_W-1:0]    src1_count_r;
  logic [atscm_pkg::CNT_W-1:0]    src2_count_r;
  logic [atscm_pkg::LABEL_W-1:0]  center_label_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_labels_r   <= '0;
      src1_labels_r  <= '0;
      src2_labels_r  <= '0;
      out_count_r    <= atscm_pkg::CNT_W'(1);
      src1_count_r   <= atscm_pkg::CNT_W'(1);
      src2_count_r   <= atscm_pkg::CNT_W'(1);
      center_label_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (atscm_pkg::cfg_idx_t'(cfg_index))
        atscm_pkg::CFG_OUT_LABELS:   out_labels_r   <= cfg_data;
        atscm_pkg::CFG_SRC1_LABELS:  src1_labels_r  <= cfg_data;
        atscm_pkg::CFG_SRC2_LABELS:  src2_labels_r  <= cfg_data;
        atscm_pkg::CFG_OUT_COUNT:    out_count_r    <= cfg_data[atscm_pkg::CNT_W-1:0];
        atscm_pkg::CFG_SRC1_COUNT:   src1_count_r   <= cfg_data[atscm_pkg::CNT_W-1:0];
        atscm_pkg::CFG_SRC2_COUNT:   src2_count_r   <= cfg_data[atscm_pkg::CNT_W-1:0];
        atscm_pkg::CFG_CENTER_LABEL: center_label_r <= cfg_data[atscm_pkg::LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [atscm_pkg::CNT_W-1:0] oc;
  atscm_pkg::src_map_t         map1;
  atscm_pkg::src_map_t         map2;
  atscm_pkg::frame_t           a_frame;
  atscm_pkg::frame_t           b_frame;
  atscm_pkg::frame_t           lane_o;

  assign oc          = atscm_pkg::eff_count(out_count_r);
  assign map1.labels = src1_labels_r;
  assign map1.cnt    = atscm_pkg::eff_count(src1_count_r);
  assign map2.labels = src2_labels_r;
  assign map2.cnt    = atscm_pkg::eff_count(src2_count_r);
  assign a_frame     = {in_a_ch3, in_a_ch2, in_a_ch1, in_a_ch0};
  assign b_frame     = {in_b_ch3, in_b_ch2, in_b_ch1, in_b_ch0};

  // pipeline control
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic s1_adv;
  logic s2_adv;
  logic in_acc;
  logic s1_ld;

  assign s2_adv   = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;
  assign s1_ld    = s1_valid_r && s2_adv;

  always_comb begin
    s1_valid_nxt  = s1_adv ? in_valid : s1_valid_r;
    out_valid_nxt = s2_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  for (genvar k = 0; k < atscm_pkg::LANES; k++) begin : g_lane
    atscm_lane u_lane (
      .src1      (map1),
      .src2      (map2),
      .center    (center_label_r),
      .out_label (out_labels_r[k*atscm_pkg::LABEL_W +: atscm_pkg::LABEL_W]),
      .lane_en   (atscm_pkg::CNT_W'(k) < oc),
      .a         (a_frame),
      .b         (b_frame),
      .o         (lane_o[k])
    );
  end

  atscm_pkg::sample_t mono_avg;

  atscm_mono u_mono (
    .clk (clk),
    .ld  (in_acc),
    .b   (b_frame),
    .c2  (map2.cnt),
    .avg (mono_avg)
  );

  atscm_pkg::frame_t s1_lane_r;
  logic              s1_mono_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_lane_r <= lane_o;
      s1_mono_r <= (oc == atscm_pkg::CNT_W'(1));
    end
  end

  // merge: mono average replaces the lanes when one output channel is used
  atscm_pkg::frame_t merged;
  atscm_pkg::frame_t out_frame_r;

  always_comb begin
    merged = s1_lane_r;
    if (s1_mono_r) begin
      merged    = '0;
      merged[0] = mono_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      out_frame_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_o_ch0 = out_frame_r[0];
  assign out_o_ch1 = out_frame_r[1];
  assign out_o_ch2 = out_frame_r[2];
  assign out_o_ch3 = out_frame_r[3];

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline slot");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted beat lost in match stage");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ld |=> out_valid_r)
    else $error("match stage advanced without filling output");

  a_mono_zero_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ld && s1_mono_r) |=> (out_o_ch1 == '0 && out_o_ch2 == '0 && out_o_ch3 == '0))
    else $error("mono frame has nonzero upper lanes");
`endif

endmodule

// ===== design/atscm_lane.sv =====
module atscm_lane (
  input  atscm_pkg::src_map_t                src1,
  input  atscm_pkg::src_map_t                src2,
  input  logic [atscm_pkg::LABEL_W-1:0]      center,
  input  logic [atscm_pkg::LABEL_W-1:0]      out_label,
  input  logic                               lane_en,
  input  atscm_pkg::frame_t                  a,
  input  atscm_pkg::frame_t                  b,
  output atscm_pkg::sample_t                 o
);

  typedef struct packed {
    logic                         hit;
    logic [atscm_pkg::IDX_W-1:0]  idx;
  } match_t;

  // lowest source channel whose label equals the target; a single
  // front-center channel matches every lane
  function automatic match_t find_src(input atscm_pkg::src_map_t m,
                                      input logic [atscm_pkg::LABEL_W-1:0] ctr,
                                      input logic [atscm_pkg::LABEL_W-1:0] tgt);
    match_t r;
    r = '0;
    for (int j = atscm_pkg::LANES - 1; j >= 0; j--) begin
      if ((atscm_pkg::CNT_W'(j) < m.cnt) &&
          (m.labels[j*atscm_pkg::LABEL_W +: atscm_pkg::LABEL_W] == tgt)) begin
        r.hit = 1'b1;
        r.idx = atscm_pkg::IDX_W'(j);
      end
    end
    if ((m.cnt == atscm_pkg::CNT_W'(1)) &&
        (m.labels[atscm_pkg::LABEL_W-1:0] == ctr)) begin
      r.hit = 1'b1;
      r.idx = '0;
    end
    return r;
  endfunction

  match_t m1;
  match_t m2;

  always_comb begin
    m1 = find_src(src1, center, out_label);
    m2 = find_src(src2, center, out_label);
    o  = '0;
    if (lane_en) begin
      if (m2.hit) begin
        o = b[m2.idx];
      end else if (m1.hit) begin
        o = a[m1.idx];
      end
    end
  end

endmodule

// ===== design/atscm_mono.sv =====
module atscm_mono (
  input  logic                           clk,
  input  logic                           ld,
  input  atscm_pkg::frame_t              b,
  input  logic [atscm_pkg::CNT_W-1:0]    c2,
  output atscm_pkg::sample_t             avg
);

  logic signed [atscm_pkg::SUM_W-1:0]   sum_nxt;
  logic signed [atscm_pkg::SUM_W-1:0]   sum_r;
  logic [atscm_pkg::CNT_W-1:0]          c2_r;
  logic [atscm_pkg::SUM_W-1:0]          mag;
  logic [2*atscm_pkg::SUM_W-1:0]        prod;
  logic [atscm_pkg::SUM_W-1:0]          qmag;
  logic [atscm_pkg::SUM_W-1:0]          q;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < atscm_pkg::LANES; k++) begin
      if (atscm_pkg::CNT_W'(k) < c2) begin
        sum_nxt = sum_nxt + atscm_pkg::SUM_W'($signed(b[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      sum_r <= sum_nxt;
      c2_r  <= c2;
    end
  end

  // truncate toward zero: divide the magnitude, then restore the sign
  always_comb begin
    mag  = sum_r[atscm_pkg::SUM_W-1] ? atscm_pkg::SUM_W'(-sum_r) : sum_r;
    prod = mag * atscm_pkg::RECIP3;
    case (c2_r)
      3'd2:    qmag = mag >> 1;
      3'd3:    qmag = atscm_pkg::SUM_W'(prod >> atscm_pkg::RECIP3_SH);
      3'd4:    qmag = mag >> 2;
      default: qmag = mag;
    endcase
    q   = sum_r[atscm_pkg::SUM_W-1] ? atscm_pkg::SUM_W'(-qmag) : qmag;
    avg = q[atscm_pkg::SAMPLE_W-1:0];
  end

endmodule
